@@ hdl/dahdsr_envelope_vca_macros.svh @@
// assertion macros shared by the envelope checker
`ifndef DAHDSR_ENVELOPE_VCA_MACROS_SVH
`define DAHDSR_ENVELOPE_VCA_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define DAHDSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DAHDSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/dahdsr_pkg.sv @@
// shared constants and codes for the envelope vca
`timescale 1ns / 1ps

package dahdsr_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 20;
	localparam int GAIN_W       = 17;
	localparam int FRAC_W       = 16;
	localparam int PC_W         = COUNT_WIDTH + 1;
	localparam int MUL_A_W      = ((COUNT_WIDTH > SAMPLE_WIDTH) ? COUNT_WIDTH : SAMPLE_WIDTH) + 1;
	localparam int PROD_W       = MUL_A_W + GAIN_W;
	localparam int DIVD_W       = COUNT_WIDTH + GAIN_W;
	localparam int STEP_W       = $clog2(GAIN_W);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = (COUNT_WIDTH > GAIN_W) ? COUNT_WIDTH : GAIN_W;
	localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((SAMPLE_WIDTH + GAIN_W + 7) / 8) * 8;

	localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);
	localparam logic [PC_W-1:0]   PC_MAX = {PC_W{1'b1}};

	// phase codes
	localparam logic [2:0] PH_DELAY   = 3'd0;
	localparam logic [2:0] PH_ATTACK  = 3'd1;
	localparam logic [2:0] PH_HOLD    = 3'd2;
	localparam logic [2:0] PH_DECAY   = 3'd3;
	localparam logic [2:0] PH_SUSTAIN = 3'd4;
	localparam logic [2:0] PH_RELEASE = 3'd5;

	// action codes
	localparam logic [1:0] ACT_PROCESS = 2'd0;
	localparam logic [1:0] ACT_RESTART = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd5;

	// how the quotient turns into a gain
	localparam logic [1:0] RAMP_NONE    = 2'd0;
	localparam logic [1:0] RAMP_ATTACK  = 2'd1;
	localparam logic [1:0] RAMP_DECAY   = 2'd2;
	localparam logic [1:0] RAMP_RELEASE = 2'd3;

	// register reset values
	localparam logic [COUNT_WIDTH-1:0] RST_DELAY   = COUNT_WIDTH'(0);
	localparam logic [COUNT_WIDTH-1:0] RST_ATTACK  = COUNT_WIDTH'(480);
	localparam logic [COUNT_WIDTH-1:0] RST_HOLD    = COUNT_WIDTH'(0);
	localparam logic [COUNT_WIDTH-1:0] RST_DECAY   = COUNT_WIDTH'(4800);
	localparam logic [COUNT_WIDTH-1:0] RST_RELEASE = COUNT_WIDTH'(4800);
	localparam logic [GAIN_W-1:0]      RST_SUSTAIN = GAIN_W'(32768);

endpackage

@@ hdl/dahdsr_mul.sv @@
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module dahdsr_mul import dahdsr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic        [GAIN_W-1:0]  b,
	output logic                      done,
	output logic signed [PROD_W-1:0]  prod
);

	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W:0]   hi_q;
	logic        [GAIN_W-1:0]  lo_q;
	logic        [STEP_W-1:0]  step_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [MUL_A_W:0]   sum;

	assign sum  = hi_q + (lo_q[0] ? {a_q[MUL_A_W-1], a_q} : {(MUL_A_W+1){1'b0}});
	assign done = done_q;
	assign prod = {hi_q[MUL_A_W-1:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add then arithmetic shift right, product bits fall into lo_q
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
		end
	end

endmodule

@@ hdl/dahdsr_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dahdsr_div import dahdsr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DIVD_W-1:0]      dividend,
	input  logic [COUNT_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [GAIN_W-1:0]      quot
);

	// quotient fits GAIN_W bits because dividend < divisor * 2**GAIN_W
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] dsr_q;
	logic [GAIN_W-1:0]      sh_q;
	logic [STEP_W-1:0]      step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [PC_W-1:0]        r2;
	logic [PC_W-1:0]        diff;
	logic                   ge;

	assign r2   = {rem_q, sh_q[GAIN_W-1]};
	assign ge   = r2 >= {1'b0, dsr_q};
	assign diff = r2 - {1'b0, dsr_q};
	assign done = done_q;
	assign quot = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend low bits shift out the top while quotient bits enter the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVD_W-1:GAIN_W];
			sh_q  <= dividend[GAIN_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_WIDTH-1:0] : r2[COUNT_WIDTH-1:0];
			sh_q  <= {sh_q[GAIN_W-2:0], ge};
		end
	end

endmodule

@@ hdl/dahdsr_envelope_vca.sv @@
// top level: dahdsr envelope generator driving a sample gain stage
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample_in  tuser: active, action
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: sample_out, gain  tuser: phase
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  an item in a flat phase (delay, hold, sustain, zero-length ramp, ended release, inactive)
//  needs only one serial multiply of the sample by the gain
//  an item in a ramp phase goes through these steps in order:
//  serial multiply index by span, serial divide by the phase length, then the
//  sample multiply; each serial unit retires one bit per cycle over the 17 gain bits
//  one item at a time; the next item is taken while a result waits in the output register
//  arst_n clears the phase state, loads the register defaults and empties the output
//  cfg_ready is always high; each write is registered on the clock edge where cfg_valid is seen
`timescale 1ns / 1ps

module dahdsr_envelope_vca import dahdsr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample stream in
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_in
	input  logic [2:0]             s_axis_tuser,  // active, action[1:0]
	// shaped stream out
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample_out, gain, zero pad
	output logic [2:0]             m_axis_tuser,  // phase
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// configuration
	logic [COUNT_WIDTH-1:0] delay_q;
	logic [COUNT_WIDTH-1:0] attack_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [COUNT_WIDTH-1:0] decay_q;
	logic [COUNT_WIDTH-1:0] release_q;
	logic [GAIN_W-1:0]      sustain_q;

	// envelope state
	logic [2:0]      phase_q;
	logic [PC_W-1:0] count_q;

	// sequencer and item context
	logic [2:0]                state_q;
	logic                      mul_start_q;
	logic                      div_start_q;
	logic                      m_valid_q;
	logic [SAMPLE_WIDTH-1:0]   x_q;
	logic [2:0]                shown_q;
	logic [1:0]                mode_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [GAIN_W-1:0]         sus_q;
	logic [COUNT_WIDTH-1:0]    n_q;
	logic signed [MUL_A_W-1:0] op_a_q;
	logic [GAIN_W-1:0]         op_b_q;
	logic [SAMPLE_WIDTH-1:0]   y_q;
	logic [GAIN_W-1:0]         out_gain_q;
	logic [2:0]                out_phase_q;

	// accept-time decode
	logic                    in_acc;
	logic [SAMPLE_WIDTH-1:0] in_x;
	logic                    in_act;
	logic [1:0]              in_action;
	logic [2:0]              ph_ev;
	logic [PC_W-1:0]         pc_ev;
	logic [COUNT_WIDTH-1:0]  n_sel;
	logic                    n_zero;
	logic [PC_W:0]           adv_c;
	logic                    adv_end;
	logic [COUNT_WIDTH-1:0]  i_cl;
	logic [GAIN_W-1:0]       sus_sat;
	logic [2:0]              ph_nx;
	logic [PC_W-1:0]         pc_nx;
	logic [1:0]              mode_nx;
	logic [GAIN_W-1:0]       g_flat;
	logic [GAIN_W-1:0]       span;
	logic [GAIN_W-1:0]       g_ramp;
	logic                    out_load;

	// serial units
	logic                     mul_done;
	logic signed [PROD_W-1:0] mul_prod;
	logic                     div_done;
	logic [GAIN_W-1:0]        div_quot;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign in_x          = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign in_act        = s_axis_tuser[0];
	assign in_action     = s_axis_tuser[2:1];

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_gain_q, y_q});
	assign m_axis_tuser  = out_phase_q;

	// sustain above unity saturates
	assign sus_sat = (sustain_q > UNITY) ? UNITY : sustain_q;

	// events take effect before the item is processed, active or not
	always_comb begin
		case (in_action)
			ACT_RESTART: begin
				ph_ev = PH_DELAY;
				pc_ev = '0;
			end
			ACT_RELEASE: begin
				ph_ev = PH_RELEASE;
				pc_ev = '0;
			end
			default: begin
				ph_ev = phase_q;
				pc_ev = count_q;
			end
		endcase
	end

	// length of the phase in force
	always_comb begin
		case (ph_ev)
			PH_DELAY:   n_sel = delay_q;
			PH_ATTACK:  n_sel = attack_q;
			PH_HOLD:    n_sel = hold_q;
			PH_DECAY:   n_sel = decay_q;
			PH_RELEASE: n_sel = release_q;
			default:    n_sel = '0;
		endcase
	end

	assign n_zero  = (n_sel == '0);
	assign adv_c   = {1'b0, pc_ev} + (PC_W+1)'(1);
	assign adv_end = adv_c > (PC_W+1)'(n_sel);
	// index clamps to the length if the length was shortened mid-phase
	assign i_cl    = (pc_ev > PC_W'(n_sel)) ? n_sel : pc_ev[COUNT_WIDTH-1:0];

	always_comb begin
		ph_nx   = ph_ev;
		pc_nx   = pc_ev;
		mode_nx = RAMP_NONE;
		g_flat  = '0;
		span    = '0;
		if (in_act) begin
			case (ph_ev)
				PH_DELAY, PH_ATTACK, PH_HOLD, PH_DECAY: begin
					// timed phase: length + 1 samples, then the next phase
					if (adv_end) begin
						ph_nx = ph_ev + 3'd1;
						pc_nx = '0;
					end else begin
						pc_nx = adv_c[PC_W-1:0];
					end
					if (ph_ev == PH_HOLD) begin
						g_flat = UNITY;
					end else if (ph_ev == PH_ATTACK) begin
						if (n_zero) begin
							g_flat = UNITY;
						end else begin
							mode_nx = RAMP_ATTACK;
							span    = UNITY;
						end
					end else if (ph_ev == PH_DECAY) begin
						if (n_zero) begin
							g_flat = sus_sat;
						end else begin
							mode_nx = RAMP_DECAY;
							span    = UNITY - sus_sat;
						end
					end
				end
				PH_RELEASE: begin
					// count saturates; gain clamps at zero past the end
					if (pc_ev != PC_MAX) begin
						pc_nx = pc_ev + 1'b1;
					end
					if (!(n_zero || pc_ev >= PC_W'(n_sel))) begin
						mode_nx = RAMP_RELEASE;
						span    = sus_sat;
					end
				end
				default: begin
					g_flat = sus_sat;
				end
			endcase
		end
	end

	// turn the ramp quotient into the gain
	always_comb begin
		case (mode_q)
			RAMP_ATTACK:  g_ramp = div_quot;
			RAMP_DECAY:   g_ramp = UNITY - div_quot;
			RAMP_RELEASE: g_ramp = sus_q - div_quot;
			default:      g_ramp = div_quot;
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= RST_DELAY;
			attack_q    <= RST_ATTACK;
			hold_q      <= RST_HOLD;
			decay_q     <= RST_DECAY;
			release_q   <= RST_RELEASE;
			sustain_q   <= RST_SUSTAIN;
			phase_q     <= PH_DELAY;
			count_q     <= '0;
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY:   delay_q   <= cfg_data[COUNT_WIDTH-1:0];
					REG_ATTACK:  attack_q  <= cfg_data[COUNT_WIDTH-1:0];
					REG_HOLD:    hold_q    <= cfg_data[COUNT_WIDTH-1:0];
					REG_DECAY:   decay_q   <= cfg_data[COUNT_WIDTH-1:0];
					REG_RELEASE: release_q <= cfg_data[COUNT_WIDTH-1:0];
					REG_SUSTAIN: sustain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						phase_q     <= ph_nx;
						count_q     <= pc_nx;
						mul_start_q <= 1'b1;
						state_q     <= (mode_nx == RAMP_NONE) ? ST_MUL2 : ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (mul_done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (mul_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item context and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q     <= in_x;
			shown_q <= ph_ev;
			mode_q  <= mode_nx;
			sus_q   <= sus_sat;
			n_q     <= n_sel;
			if (mode_nx == RAMP_NONE) begin
				gain_q <= g_flat;
				op_a_q <= {{(MUL_A_W-SAMPLE_WIDTH){in_x[SAMPLE_WIDTH-1]}}, in_x};
				op_b_q <= g_flat;
			end else begin
				op_a_q <= {{(MUL_A_W-COUNT_WIDTH){1'b0}}, i_cl};
				op_b_q <= span;
			end
		end
		if ((state_q == ST_DIV) && div_done) begin
			gain_q <= g_ramp;
			op_a_q <= {{(MUL_A_W-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};
			op_b_q <= g_ramp;
		end
		if (out_load) begin
			// arithmetic shift floors the q16 product
			y_q         <= mul_prod[FRAC_W+SAMPLE_WIDTH-1:FRAC_W];
			out_gain_q  <= gain_q;
			out_phase_q <= shown_q;
		end
	end

	// index times span for a ramp, then sample times gain
	dahdsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// ramp quotient floor(i * span / n)
	dahdsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (mul_prod[DIVD_W-1:0]),
		.divisor  (n_q),
		.done     (div_done),
		.quot     (div_quot)
	);

endmodule

@@ hdl/dahdsr_chk.sv @@
// port-level checker for the envelope vca, bound to the top level
`timescale 1ns / 1ps
`include "dahdsr_envelope_vca_macros.svh"

module dahdsr_chk import dahdsr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [2:0]             m_axis_tuser
);

	logic [GAIN_W-1:0]       out_gain;
	logic [SAMPLE_WIDTH-1:0] out_smp;

	assign out_gain = m_axis_tdata[SAMPLE_WIDTH+GAIN_W-1:SAMPLE_WIDTH];
	assign out_smp  = m_axis_tdata[SAMPLE_WIDTH-1:0];

	`DAHDSR_ASSERT_IMP(a_gain_range, m_axis_tvalid, out_gain <= UNITY, "gain above unity")
	`DAHDSR_ASSERT_IMP(a_delay_silent, m_axis_tvalid && m_axis_tuser == PH_DELAY, out_gain == '0, "delay phase with nonzero gain")
	`DAHDSR_ASSERT_IMP(a_zero_gain, m_axis_tvalid && out_gain == '0, out_smp == '0, "zero gain but nonzero sample")
	`DAHDSR_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
	`DAHDSR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind dahdsr_envelope_vca dahdsr_chk u_chk (.*);

@@ bench/tb.sv @@
// self-checking testbench for the dahdsr envelope vca
`timescale 1ns / 1ps

module tb;
	import dahdsr_pkg::*;

	// action code 3 is not in the package: the block treats it as plain processing
	localparam logic [1:0]             ACT_SPARE = 2'd3;
	localparam logic [CFG_DATA_W-1:0]  LEN_MAX   = CFG_DATA_W'(20'hFFFFF);

	// one shaped sample as it leaves the block
	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] smp;
		logic [GAIN_W-1:0]       gain;
		logic [2:0]              phase;
	} env_result_t;

	// one row of the directed table: a register write or a sample item
	typedef struct packed {
		bit                      is_reg;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   value;
		logic [SAMPLE_WIDTH-1:0] smp;
		logic                    act;
		logic [1:0]              op;
		bit                      typed;
		env_result_t             want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // sample_in
	logic [2:0]             s_axis_tuser = '0;   // active, action[1:0]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // sample_out, gain, zero pad
	logic [2:0]             m_axis_tuser;        // phase
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// envelope state and register copies kept by the predictor
	logic [2:0]             env_phase   = PH_DELAY;
	logic [PC_W-1:0]        env_count   = '0;
	logic [COUNT_WIDTH-1:0] len_delay   = RST_DELAY;
	logic [COUNT_WIDTH-1:0] len_attack  = RST_ATTACK;
	logic [COUNT_WIDTH-1:0] len_hold    = RST_HOLD;
	logic [COUNT_WIDTH-1:0] len_decay   = RST_DECAY;
	logic [COUNT_WIDTH-1:0] len_release = RST_RELEASE;
	logic [GAIN_W-1:0]      sustain_reg = RST_SUSTAIN;

	env_result_t shaped_q [$];
	int          mismatch_cnt = 0;
	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;

	dahdsr_envelope_vca i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	// floor(idx * span / len), idx clamped to len; len is never zero here
	function automatic longint unsigned ramp_gain(input longint unsigned idx,
			input longint unsigned span, input longint unsigned len);
		if (idx > len)
			idx = len;
		return (idx * span) / len;
	endfunction

	// timed phase: lasts len+1 samples, then hands over to the next phase
	function automatic void step_timed(input longint unsigned len, input logic [2:0] next);
		if (longint'(env_count) + 1 > len) begin
			env_phase = next;
			env_count = '0;
		end else begin
			env_count = env_count + 1'b1;
		end
	endfunction

	// envelope gain for one sample, state advanced, product floored
	function automatic env_result_t shape_sample(input logic [SAMPLE_WIDTH-1:0] smp,
			input logic act, input logic [1:0] op);
		env_result_t     r;
		longint unsigned s, n, idx, g;
		longint          p;
		logic [2:0]      shown;
		s = (sustain_reg > UNITY) ? longint'(UNITY) : longint'(sustain_reg);
		// events land before the sample, active or not
		if (op == ACT_RESTART) begin
			env_phase = PH_DELAY;
			env_count = '0;
		end else if (op == ACT_RELEASE) begin
			env_phase = PH_RELEASE;
			env_count = '0;
		end
		shown = env_phase;
		g = 0;
		if (act) begin
			idx = env_count;
			case (env_phase)
				PH_DELAY: begin
					step_timed(len_delay, PH_ATTACK);
				end
				PH_ATTACK: begin
					n = len_attack;
					step_timed(n, PH_HOLD);
					g = (n == 0) ? longint'(UNITY) : ramp_gain(idx, UNITY, n);
				end
				PH_HOLD: begin
					step_timed(len_hold, PH_DECAY);
					g = UNITY;
				end
				PH_DECAY: begin
					n = len_decay;
					step_timed(n, PH_SUSTAIN);
					g = (n == 0) ? s : UNITY - ramp_gain(idx, UNITY - s, n);
				end
				PH_RELEASE: begin
					n = len_release;
					if (env_count != PC_MAX)
						env_count = env_count + 1'b1;
					g = (n == 0 || idx >= n) ? 0 : s - ramp_gain(idx, s, n);
				end
				default: begin
					g = s;
				end
			endcase
		end
		p = longint'($signed(smp)) * longint'(g);
		r.smp   = SAMPLE_WIDTH'(p >>> FRAC_W);
		r.gain  = GAIN_W'(g);
		r.phase = shown;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		stim_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.value  = value;
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [SAMPLE_WIDTH-1:0] smp,
			input logic act, input logic [1:0] op);
		stim_row_t r;
		r = '0;
		r.smp = smp;
		r.act = act;
		r.op  = op;
		return r;
	endfunction

	// item whose result is obvious from the envelope definition
	function automatic stim_row_t chk_row(input logic [SAMPLE_WIDTH-1:0] smp,
			input logic act, input logic [1:0] op, input logic [SAMPLE_WIDTH-1:0] y,
			input logic [GAIN_W-1:0] g, input logic [2:0] ph);
		stim_row_t r;
		r = item_row(smp, act, op);
		r.typed = 1'b1;
		r.want  = '{smp: y, gain: g, phase: ph};
		return r;
	endfunction

	// mostly short phases so the envelope walks all the way round
	function automatic logic [CFG_DATA_W-1:0] pick_len();
		case ($urandom_range(0, 15))
			0:       return LEN_MAX;
			1:       return CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
			2:       return '0;
			default: return CFG_DATA_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_sustain();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return CFG_DATA_W'(UNITY);
			2:       return CFG_DATA_W'($urandom_range(65537, 131071));  // saturates to unity
			default: return CFG_DATA_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// present one sample item, hold it until taken, then queue its result
	task automatic send_item(input logic [SAMPLE_WIDTH-1:0] smp, input logic act,
			input logic [1:0] op, input bit typed, input env_result_t want);
		env_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(smp);
		s_axis_tuser  <= {op, act};
		do @(posedge clk); while (!s_axis_tready);
		// predictor always runs so its state tracks the block
		predicted = shape_sample(smp, act, op);
		shaped_q.push_back(typed ? want : predicted);
	endtask

	// stop sending and wait until every queued result has come out
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
	endtask

	// one register write, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DELAY:   len_delay   = value[COUNT_WIDTH-1:0];
			REG_ATTACK:  len_attack  = value[COUNT_WIDTH-1:0];
			REG_HOLD:    len_hold    = value[COUNT_WIDTH-1:0];
			REG_DECAY:   len_decay   = value[COUNT_WIDTH-1:0];
			REG_RELEASE: len_release = value[COUNT_WIDTH-1:0];
			REG_SUSTAIN: sustain_reg = value[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver backpressure, redrawn every cycle
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// result checker: every taken item against the oldest expectation
	always @(posedge clk) begin : check_out
		env_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.smp   = m_axis_tdata[SAMPLE_WIDTH-1:0];
			got.gain  = m_axis_tdata[SAMPLE_WIDTH+GAIN_W-1:SAMPLE_WIDTH];
			got.phase = m_axis_tuser;
			if (shaped_q.size() == 0) begin
				$display("%t unexpected item: sample_out %0d gain %0d phase %0d",
					$time, $signed(got.smp), got.gain, got.phase);
				mismatch_cnt++;
			end else begin
				want = shaped_q.pop_front();
				if (got.smp !== want.smp) begin
					$display("%t sample_out expected %0d got %0d",
						$time, $signed(want.smp), $signed(got.smp));
					mismatch_cnt++;
				end
				if (got.gain !== want.gain) begin
					$display("%t gain expected %0d got %0d", $time, want.gain, got.gain);
					mismatch_cnt++;
				end
				if (got.phase !== want.phase) begin
					$display("%t phase expected %0d got %0d", $time, want.phase, got.phase);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		stim_row_t               dir_rows [$];
		logic [SAMPLE_WIDTH-1:0] smp;
		logic                    act;
		logic [1:0]              op;
		int                      roll;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 29;
		rx_idle_pct = 65;

		dir_rows = '{
			// register defaults after reset: zero-length delay, attack starts at zero
			chk_row(16'h7FFF, 1'b1, ACT_PROCESS, 16'h0000, 17'd0, PH_DELAY),
			chk_row(16'h8000, 1'b1, ACT_PROCESS, 16'h0000, 17'd0, PH_ATTACK),
			// release event still lands while inactive, output silent
			chk_row(16'h8000, 1'b0, ACT_RELEASE, 16'h0000, 17'd0, PH_RELEASE),
			// every ramp zero length, sustain above unity
			reg_row(REG_DELAY, '0),
			reg_row(REG_ATTACK, '0),
			reg_row(REG_HOLD, '0),
			reg_row(REG_DECAY, '0),
			reg_row(REG_RELEASE, '0),
			reg_row(REG_SUSTAIN, CFG_DATA_W'(20'h1FFFF)),
			chk_row(16'h0001, 1'b1, ACT_RESTART, 16'h0000, 17'd0, PH_DELAY),
			chk_row(16'h8000, 1'b1, ACT_PROCESS, 16'h8000, UNITY, PH_ATTACK),
			chk_row(16'h7FFF, 1'b1, ACT_SPARE, 16'h7FFF, UNITY, PH_HOLD),
			chk_row(16'hFFFF, 1'b1, ACT_PROCESS, 16'hFFFF, UNITY, PH_DECAY),
			chk_row(16'd12345, 1'b1, ACT_PROCESS, 16'd12345, UNITY, PH_SUSTAIN),
			chk_row(16'h8000, 1'b0, ACT_PROCESS, 16'h0000, 17'd0, PH_SUSTAIN),
			chk_row(16'd1000, 1'b1, ACT_RELEASE, 16'h0000, 17'd0, PH_RELEASE),
			// short ramps: one full pass through every phase
			reg_row(REG_ATTACK, CFG_DATA_W'(2)),
			reg_row(REG_DECAY, CFG_DATA_W'(2)),
			reg_row(REG_RELEASE, CFG_DATA_W'(1)),
			reg_row(REG_SUSTAIN, CFG_DATA_W'(40000)),
			item_row(16'h7FFF, 1'b1, ACT_RESTART),
			item_row(16'hFFFF, 1'b1, ACT_PROCESS),
			item_row(16'hFFFF, 1'b1, ACT_PROCESS),  // half gain on -1 floors to -1
			item_row(16'h8000, 1'b1, ACT_PROCESS),
			item_row(16'h1234, 1'b1, ACT_PROCESS),
			item_row(16'hC000, 1'b1, ACT_PROCESS),
			item_row(16'h7FFF, 1'b1, ACT_PROCESS),
			item_row(16'h8001, 1'b1, ACT_PROCESS),
			item_row(16'h5555, 1'b1, ACT_PROCESS),
			item_row(16'hAAAA, 1'b1, ACT_RELEASE),
			item_row(16'h0001, 1'b1, ACT_PROCESS),  // past the end of release
			// longest phases, unity sustain
			reg_row(REG_DELAY, LEN_MAX),
			reg_row(REG_ATTACK, LEN_MAX),
			reg_row(REG_HOLD, LEN_MAX),
			reg_row(REG_DECAY, LEN_MAX),
			reg_row(REG_RELEASE, LEN_MAX),
			reg_row(REG_SUSTAIN, CFG_DATA_W'(UNITY)),
			item_row(16'h7FFF, 1'b1, ACT_RESTART),
			item_row(16'h8000, 1'b1, ACT_PROCESS),
			item_row(16'h8000, 1'b1, ACT_RELEASE),
			item_row(16'h7FFF, 1'b1, ACT_PROCESS)
		};

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_reg) begin
				drain();
				write_reg(dir_rows[k].idx, dir_rows[k].value);
			end else begin
				send_item(dir_rows[k].smp, dir_rows[k].act, dir_rows[k].op,
					dir_rows[k].typed, dir_rows[k].want);
			end
		end

		// random part: three idling patterns, four register settings each
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 29;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 29;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int setting = 0; setting < 4; setting++) begin
				// state carries over the writes, but the first item below restarts the envelope
				drain();
				write_reg(REG_DELAY, pick_len());
				write_reg(REG_ATTACK, pick_len());
				write_reg(REG_HOLD, pick_len());
				write_reg(REG_DECAY, pick_len());
				write_reg(REG_RELEASE, pick_len());
				write_reg(REG_SUSTAIN, pick_sustain());
				for (int k = 0; k < 125; k++) begin
					// first item of a setting restarts the envelope; events otherwise rare
					roll = (k == 0) ? 0 : $urandom_range(0, 99);
					if (roll < 4)
						op = ACT_RESTART;
					else if (roll < 8)
						op = ACT_RELEASE;
					else if (roll < 10)
						op = ACT_SPARE;
					else
						op = ACT_PROCESS;
					act = ($urandom_range(0, 9) != 0);
					case ($urandom_range(0, 15))
						0:       smp = 16'h8000;
						1:       smp = 16'h7FFF;
						2:       smp = 16'hFFFF;
						default: smp = SAMPLE_WIDTH'($urandom);
					endcase
					send_item(smp, act, op, 1'b0, '0);
				end
			end
		end

		drain();
		// let any stray item show up before the verdict
		repeat (100) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dahdsr_pkg.sv
hdl/dahdsr_mul.sv
hdl/dahdsr_div.sv
hdl/dahdsr_envelope_vca.sv
hdl/dahdsr_chk.sv
bench/tb.sv
